### hdl/i2cswr_pkg.sv
// ----------------------------------------------------------------------------
// I2C slave clock and wind responder package
// Shared types, event codes and register indexes for the responder and its
// checker.
// ----------------------------------------------------------------------------
package i2cswr_pkg;

	localparam int CLK_BYTES  = 8;
	localparam int WIND_BYTES = 4;

	typedef enum logic [1:0] {
		KIND_RX   = 2'd0,
		KIND_REQ  = 2'd1,
		KIND_STOP = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_CMD_SET_CLOCK  = 2'd0,
		REG_CMD_READ_CLOCK = 2'd1,
		REG_CMD_READ_WIND  = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_SET       = 3'd1,
		MODE_RCLK_CMD  = 3'd2,
		MODE_RCLK      = 3'd3,
		MODE_RWIND_CMD = 3'd4,
		MODE_RWIND     = 3'd5
	} mode_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  rx_byte;
		logic [11:0] now_year;
		logic [3:0]  now_month;
		logic [4:0]  now_day;
		logic [2:0]  now_weekday;
		logic [4:0]  now_hour;
		logic [5:0]  now_minute;
		logic [5:0]  now_second;
		logic [31:0] wind_bits;
	} item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        set_strobe;
		logic [15:0] set_year;
		logic [7:0]  set_month;
		logic [7:0]  set_day;
		logic [7:0]  set_weekday;
		logic [7:0]  set_hour;
		logic [7:0]  set_minute;
		logic [7:0]  set_second;
	} result_t;

endpackage

### hdl/i2c_slave_clock_and_wind_responder.sv
// ----------------------------------------------------------------------------
// I2C slave clock and wind responder
// Interprets one bus event per transfer: commands, clock writes, and byte
// reads of the clock and wind buffers.
// ----------------------------------------------------------------------------
// An event moves from the input register into the result register; it leaves the
// input register only when the result register is empty or being taken.
// Throughput: one event per cycle while result_ready does not hold the result; the
// mode and index update completes in the cycle the event leaves the input register, so the next event sees it.
// Reset: arst_n clears the mode, indexes and buffers, and loads the command
// registers with 1, 2 and 3.
module i2c_slave_clock_and_wind_responder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_wdata,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  i2cswr_pkg::item_t    item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output i2cswr_pkg::result_t  result
);
	import i2cswr_pkg::*;

	logic [7:0]  cmd_set_clock_q, cmd_read_clock_q, cmd_read_wind_q;
	mode_t       mode_q, mode_d;
	logic [7:0]  clk_buf_q [CLK_BYTES];
	logic [7:0]  clk_buf_d [CLK_BYTES];
	logic [7:0]  wind_buf_q [WIND_BYTES];
	logic [7:0]  wind_buf_d [WIND_BYTES];
	logic [3:0]  clk_idx_q, clk_idx_d;
	logic [2:0]  wind_idx_q, wind_idx_d;

	logic        valid_s1;
	item_t       item_s1;
	logic        result_valid_q;
	result_t     result_q;
	result_t     res_d;
	logic        advance;

	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_set_clock_q  <= 8'd1;
			cmd_read_clock_q <= 8'd2;
			cmd_read_wind_q  <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CMD_SET_CLOCK:  cmd_set_clock_q  <= cfg_wdata;
				REG_CMD_READ_CLOCK: cmd_read_clock_q <= cfg_wdata;
				REG_CMD_READ_WIND:  cmd_read_wind_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		mode_d     = mode_q;
		clk_buf_d  = clk_buf_q;
		wind_buf_d = wind_buf_q;
		clk_idx_d  = clk_idx_q;
		wind_idx_d = wind_idx_q;
		res_d      = '0;
		if (advance) begin
			unique case (item_s1.kind)
				KIND_RX, KIND_REQ: begin
					if (item_s1.kind == KIND_RX && mode_q == MODE_IDLE) begin
						priority if (item_s1.rx_byte == cmd_set_clock_q) begin
							mode_d    = MODE_SET;
							clk_idx_d = '0;
							for (int i = 0; i < CLK_BYTES; i++) begin
								clk_buf_d[i] = '0;
							end
						end else if (item_s1.rx_byte == cmd_read_clock_q) begin
							mode_d       = MODE_RCLK_CMD;
							clk_idx_d    = '0;
							clk_buf_d[0] = {4'd0, item_s1.now_year[11:8]};
							clk_buf_d[1] = item_s1.now_year[7:0];
							clk_buf_d[2] = {4'd0, item_s1.now_month};
							clk_buf_d[3] = {3'd0, item_s1.now_day};
							clk_buf_d[4] = {5'd0, item_s1.now_weekday};
							clk_buf_d[5] = {3'd0, item_s1.now_hour};
							clk_buf_d[6] = {2'd0, item_s1.now_minute};
							clk_buf_d[7] = {2'd0, item_s1.now_second};
						end else if (item_s1.rx_byte == cmd_read_wind_q) begin
							mode_d        = MODE_RWIND_CMD;
							wind_idx_d    = '0;
							wind_buf_d[0] = item_s1.wind_bits[7:0];
							wind_buf_d[1] = item_s1.wind_bits[15:8];
							wind_buf_d[2] = item_s1.wind_bits[23:16];
							wind_buf_d[3] = item_s1.wind_bits[31:24];
						end else begin
						end
					end else if (item_s1.kind == KIND_RX && mode_q == MODE_SET) begin
						if (clk_idx_q < 4'(CLK_BYTES)) begin
							clk_buf_d[clk_idx_q[2:0]] = item_s1.rx_byte;
							clk_idx_d = clk_idx_q + 4'd1;
						end
					end else if (mode_q == MODE_RCLK) begin
						res_d.tx_valid = 1'b1;
						if (clk_idx_q < 4'(CLK_BYTES)) begin
							res_d.tx_byte = clk_buf_q[clk_idx_q[2:0]];
							clk_idx_d     = clk_idx_q + 4'd1;
						end
					end else if (mode_q == MODE_RWIND) begin
						res_d.tx_valid = 1'b1;
						if (wind_idx_q < 3'(WIND_BYTES)) begin
							res_d.tx_byte = wind_buf_q[wind_idx_q[1:0]];
							wind_idx_d    = wind_idx_q + 3'd1;
						end
					end
				end
				KIND_STOP: begin
					unique case (mode_q)
						MODE_SET: begin
							res_d.set_strobe  = 1'b1;
							res_d.set_year    = {clk_buf_q[0], clk_buf_q[1]};
							res_d.set_month   = clk_buf_q[2];
							res_d.set_day     = clk_buf_q[3];
							res_d.set_weekday = clk_buf_q[4];
							res_d.set_hour    = clk_buf_q[5];
							res_d.set_minute  = clk_buf_q[6];
							res_d.set_second  = clk_buf_q[7];
							clk_idx_d         = '0;
							mode_d            = MODE_IDLE;
						end
						MODE_RCLK_CMD: begin
							mode_d    = MODE_RCLK;
							clk_idx_d = '0;
						end
						MODE_RWIND_CMD: begin
							mode_d     = MODE_RWIND;
							wind_idx_d = '0;
						end
						MODE_RCLK: begin
							clk_idx_d = '0;
							mode_d    = MODE_IDLE;
						end
						MODE_RWIND: begin
							wind_idx_d = '0;
							mode_d     = MODE_IDLE;
						end
						default: mode_d = MODE_IDLE;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			clk_idx_q  <= '0;
			wind_idx_q <= '0;
			for (int i = 0; i < CLK_BYTES; i++) begin
				clk_buf_q[i] <= '0;
			end
			for (int i = 0; i < WIND_BYTES; i++) begin
				wind_buf_q[i] <= '0;
			end
		end else begin
			mode_q     <= mode_d;
			clk_idx_q  <= clk_idx_d;
			wind_idx_q <= wind_idx_d;
			clk_buf_q  <= clk_buf_d;
			wind_buf_q <= wind_buf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_d;
		end
	end

endmodule

### hdl/i2cswr_checker.sv
// ----------------------------------------------------------------------------
// I2C slave clock and wind responder checker
// Port-level properties of the responder, bound to its top level.
// ----------------------------------------------------------------------------
module i2cswr_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  i2cswr_pkg::result_t  result
);
	import i2cswr_pkg::*;

	// A set transfer never also supplies a byte to the master.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.set_strobe |-> !result.tx_valid)
	else $error("set strobe together with a supplied byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.set_strobe |->
			result.set_year == '0 && result.set_month == '0 && result.set_day == '0 &&
			result.set_weekday == '0 && result.set_hour == '0 &&
			result.set_minute == '0 && result.set_second == '0)
	else $error("set fields not zero without set strobe");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.tx_valid |-> result.tx_byte == '0)
	else $error("byte present without a supplied byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
	else $error("stalled result changed or dropped");

endmodule

bind i2c_slave_clock_and_wind_responder i2cswr_checker u_i2cswr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
